// ===== hdl/tsw_pkg.sv =====
// tsw_pkg: shared types and constants of the tcp sender window block
// payload words, controller/datapath command and status structs, codes
// no dependencies
package tsw_pkg;

  // input actions
  localparam logic [2:0] ACT_WRITE = 3'd0;
  localparam logic [2:0] ACT_FILL  = 3'd1;
  localparam logic [2:0] ACT_ACK   = 3'd2;
  localparam logic [2:0] ACT_TICK  = 3'd3;
  localparam logic [2:0] ACT_EMPTY = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_NEW    = 2'd0;
  localparam logic [1:0] KIND_RETX   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_ISN = 2'd0;
  localparam logic [1:0] REG_TMO = 2'd1;
  localparam logic [1:0] REG_CAP = 2'd2;

  localparam logic [31:0] ISN_RST = 32'd0;
  localparam logic [15:0] TMO_RST = 16'd1000;
  localparam logic [15:0] CAP_RST = 16'd64000;

  // stored payload length width, covers any legal max payload
  localparam int LEN_W = 14;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] write_len;
    logic        end_input;
    logic [31:0] ack_number;
    logic [15:0] advertised_window;
    logic [15:0] elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] wrapped_seqno;
    logic        syn_flag;
    logic        fin_flag;
    logic [10:0] payload_len;
    logic        last;
    logic [15:0] flight_bytes;
    logic [15:0] retry_count;
    logic [15:0] written_accepted;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       do_write;
    logic       unwrap;
    logic       rd_head;
    logic       rd_out;
    logic       retire;
    logic       set_win;
    logic       fill_begin;
    logic       fill_step;
    logic       tick;
    logic       retx_upd;
    logic       out_next;
    logic       emit;
    logic [1:0] emit_kind;
    logic       emit_last;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       ack_ok;
    logic       count_nz;
    logic       head_done;
    logic       fill_go;
    logic       nseg_nz;
    logic       out_last;
    logic       expire;
  } stat_t;

endpackage

// ===== hdl/tsw_regs.sv =====
// tsw_regs: apb configuration registers of the tcp sender window block
// depends on tsw_pkg
module tsw_regs
  import tsw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] isn_o,
  output logic [15:0] init_tmo_o,
  output logic [15:0] capacity_o
);

  logic [31:0] isn_q;
  logic [15:0] tmo_q;
  logic [15:0] cap_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      isn_q <= ISN_RST;
      tmo_q <= TMO_RST;
      cap_q <= CAP_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_ISN: isn_q <= pwdata;
        REG_TMO: tmo_q <= pwdata[15:0];
        REG_CAP: cap_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ISN: prdata = isn_q;
      REG_TMO: prdata = {16'd0, tmo_q};
      REG_CAP: prdata = {16'd0, cap_q};
      default: prdata = 32'd0;
    endcase
  end

  assign isn_o      = isn_q;
  assign init_tmo_o = tmo_q;
  assign capacity_o = cap_q;

endmodule

// ===== hdl/tsw_ctrl.sv =====
// tsw_ctrl: sequencer of the tcp sender window block
// walks each action through the datapath; depends on tsw_pkg
module tsw_ctrl
  import tsw_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  input  stat_t st_i,
  output cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_ACK_CHECK, S_ACK_RD, S_ACK_CHK, S_FILL, S_OUT_RD,
    S_OUT_EMIT, S_TICK_CHK, S_TICK_UPD, S_RETX_EMIT, S_EMPTY, S_STATUS
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;

  always_comb begin
    state_d = state_q;
    busy_d  = busy_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          busy_d     = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st_i.action)
          ACT_WRITE: begin
            cmd_o.do_write = 1'b1;
            state_d        = S_STATUS;
          end
          ACT_FILL: begin
            cmd_o.fill_begin = 1'b1;
            state_d          = S_FILL;
          end
          ACT_ACK: begin
            cmd_o.unwrap = 1'b1;
            state_d      = S_ACK_CHECK;
          end
          ACT_TICK: begin
            cmd_o.tick = 1'b1;
            state_d    = S_TICK_CHK;
          end
          ACT_EMPTY: state_d = S_EMPTY;
          default:   state_d = S_STATUS;
        endcase
      end
      S_ACK_CHECK: state_d = st_i.ack_ok ? S_ACK_RD : S_STATUS;
      S_ACK_RD: begin
        if (st_i.count_nz) begin
          cmd_o.rd_head = 1'b1;
          state_d       = S_ACK_CHK;
        end else begin
          cmd_o.set_win    = 1'b1;
          cmd_o.fill_begin = 1'b1;
          state_d          = S_FILL;
        end
      end
      S_ACK_CHK: begin
        if (st_i.head_done) begin
          cmd_o.retire = 1'b1;
          state_d      = S_ACK_RD;
        end else begin
          cmd_o.set_win    = 1'b1;
          cmd_o.fill_begin = 1'b1;
          state_d          = S_FILL;
        end
      end
      S_FILL: begin
        if (st_i.fill_go) begin
          cmd_o.fill_step = 1'b1;
        end else if (st_i.nseg_nz) begin
          state_d = S_OUT_RD;
        end else begin
          state_d = S_STATUS;
        end
      end
      S_OUT_RD: begin
        cmd_o.rd_out = 1'b1;
        state_d      = S_OUT_EMIT;
      end
      S_OUT_EMIT: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_kind = KIND_NEW;
        cmd_o.emit_last = st_i.out_last;
        cmd_o.out_next  = 1'b1;
        if (st_i.out_last) begin
          busy_d  = 1'b0;
          state_d = S_IDLE;
        end else begin
          state_d = S_OUT_RD;
        end
      end
      S_TICK_CHK: begin
        if (st_i.expire) begin
          cmd_o.rd_head = 1'b1;
          state_d       = S_TICK_UPD;
        end else begin
          state_d = S_STATUS;
        end
      end
      S_TICK_UPD: begin
        cmd_o.retx_upd = 1'b1;
        state_d        = S_RETX_EMIT;
      end
      S_RETX_EMIT: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_kind = KIND_RETX;
        cmd_o.emit_last = 1'b1;
        busy_d          = 1'b0;
        state_d         = S_IDLE;
      end
      S_EMPTY: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_kind = KIND_EMPTY;
        cmd_o.emit_last = 1'b1;
        busy_d          = 1'b0;
        state_d         = S_IDLE;
      end
      S_STATUS: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_kind = KIND_STATUS;
        cmd_o.emit_last = 1'b1;
        busy_d          = 1'b0;
        state_d         = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy = busy_q;

endmodule

// ===== hdl/tsw_dp.sv =====
// tsw_dp: datapath of the tcp sender window block
// sender state, in-flight queue memory, result register; depends on tsw_pkg
module tsw_dp
  import tsw_pkg::*;
#(
  parameter int MAX_PAYLOAD  = 1452,
  parameter int FLIGHT_DEPTH = 64,
  parameter int SEQ_WIDTH    = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_item_t    item_i,
  input  logic [31:0] isn_i,
  input  logic [15:0] init_tmo_i,
  input  logic [15:0] capacity_i,
  input  cmd_t        cmd_i,
  output stat_t       st_o,
  output logic        res_valid_o,
  output out_item_t   res_o
);

  localparam int SW   = SEQ_WIDTH;
  localparam int QW   = $clog2(FLIGHT_DEPTH);
  localparam int CW   = $clog2(FLIGHT_DEPTH + 1);
  localparam int SUMW = CW + 1;
  localparam int EW   = SW + LEN_W + 2;
  localparam logic [15:0] MAXP = 16'(MAX_PAYLOAD);
  localparam logic [SUMW-1:0] DEPTH_S = SUMW'(FLIGHT_DEPTH);
  localparam logic [SW:0] TWO32 = (SW+1)'(1) << 32;
  localparam logic [SW-1:0] HALF = SW'(1) << 31;

  // sender state
  logic [SW-1:0] next_q;
  logic [15:0]   bo_q, win_q, retries_q, buf_q, acc_q;
  logic          syn_sent_q, fin_sent_q, ended_q;
  logic [31:0]   timer_q, tmo_q;
  logic [QW-1:0] head_q, fstart_q;
  logic [CW-1:0] count_q, nseg_q, oidx_q;
  in_item_t      item_q;
  logic [SW:0]   ack_abs_q;

  logic [EW-1:0] mem [FLIGHT_DEPTH];
  logic [EW-1:0] rdata_q;
  out_item_t     res_q;
  logic          res_valid_q;

  // circular index sums
  logic [SUMW-1:0] tail_sum, head_sum, out_sum;
  logic [QW-1:0]   tail_idx, head_nxt, out_idx, rd_idx;

  assign tail_sum = SUMW'(head_q) + SUMW'(count_q);
  assign head_sum = SUMW'(head_q) + SUMW'(1);
  assign out_sum  = SUMW'(fstart_q) + SUMW'(oidx_q);
  assign tail_idx = QW'(tail_sum >= DEPTH_S ? tail_sum - DEPTH_S : tail_sum);
  assign head_nxt = QW'(head_sum >= DEPTH_S ? head_sum - DEPTH_S : head_sum);
  assign out_idx  = QW'(out_sum >= DEPTH_S ? out_sum - DEPTH_S : out_sum);
  assign rd_idx   = cmd_i.rd_out ? out_idx : head_q;

  // fields of the entry last read from the queue (head or output index)
  logic [SW-1:0]    r_abs;
  logic [LEN_W-1:0] r_len;
  logic             r_syn, r_fin;
  logic [SW:0]      r_end;

  assign r_abs = rdata_q[EW-1 -: SW];
  assign r_len = rdata_q[2 +: LEN_W];
  assign r_syn = rdata_q[1];
  assign r_fin = rdata_q[0];
  assign r_end = {1'b0, r_abs} + (SW+1)'(r_len) + (SW+1)'(r_syn) + (SW+1)'(r_fin);

  // segment cut
  logic [15:0] win, room, plen_a, plen, seglen;
  logic        f_syn, f_fin, f_cond, f_go;
  logic [16:0] f_sum;

  always_comb begin
    win    = (win_q == 16'd0) ? 16'd1 : win_q;
    f_syn  = !syn_sent_q;
    room   = win - bo_q - 16'(f_syn);
    plen_a = (room < MAXP) ? room : MAXP;
    plen   = (plen_a > buf_q) ? buf_q : plen_a;
    f_sum  = {1'b0, plen} + {1'b0, bo_q};
    f_fin  = !fin_sent_q && ended_q && (buf_q == plen) && (f_sum < {1'b0, win});
    f_cond = (win > bo_q) && (count_q < CW'(FLIGHT_DEPTH));
    f_go   = f_cond && (f_syn || f_fin || (plen != 16'd0));
    seglen = plen + 16'(f_syn) + 16'(f_fin);
  end

  // ack unwrap around next seqno
  logic [31:0]   off;
  logic [SW-1:0] cand;
  logic [SW:0]   abs_d;

  always_comb begin
    off  = item_q.ack_number - isn_i;
    cand = {next_q[SW-1:32], off};
    if (cand > next_q && (cand - next_q) > HALF && next_q[SW-1:32] != '0) begin
      abs_d = {1'b0, cand} - TWO32;
    end else if (cand < next_q && (next_q - cand) > HALF) begin
      abs_d = {1'b0, cand} + TWO32;
    end else begin
      abs_d = {1'b0, cand};
    end
  end

  // stream write
  logic [15:0] wroom, wacc;
  assign wroom = (capacity_i > buf_q) ? capacity_i - buf_q : 16'd0;
  assign wacc  = (item_q.write_len < wroom) ? item_q.write_len : wroom;

  // timer
  logic [32:0] tsum;
  assign tsum = {1'b0, timer_q} + 33'(item_q.elapsed_ms);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q      <= '0;
      bo_q        <= '0;
      win_q       <= 16'd1;
      syn_sent_q  <= 1'b0;
      fin_sent_q  <= 1'b0;
      timer_q     <= '0;
      tmo_q       <= 32'(TMO_RST);
      retries_q   <= '0;
      head_q      <= '0;
      count_q     <= '0;
      buf_q       <= '0;
      ended_q     <= 1'b0;
      acc_q       <= '0;
      nseg_q      <= '0;
      oidx_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit;
      if (cmd_i.load) begin
        acc_q <= '0;
      end
      if (cmd_i.do_write && !ended_q) begin
        acc_q <= wacc;
        buf_q <= buf_q + wacc;
        if (item_q.end_input) ended_q <= 1'b1;
      end
      if (cmd_i.retire) begin
        bo_q      <= bo_q - 16'(r_end - {1'b0, r_abs});
        head_q    <= head_nxt;
        count_q   <= count_q - CW'(1);
        tmo_q     <= 32'(init_tmo_i);
        timer_q   <= '0;
        retries_q <= '0;
      end
      if (cmd_i.set_win) win_q <= item_q.advertised_window;
      if (cmd_i.fill_begin) begin
        nseg_q <= '0;
        oidx_q <= '0;
      end
      if (cmd_i.fill_step) begin
        buf_q <= buf_q - plen;
        if (f_syn) syn_sent_q <= 1'b1;
        if (f_fin) fin_sent_q <= 1'b1;
        if (count_q == '0) begin
          tmo_q   <= 32'(init_tmo_i);
          timer_q <= '0;
        end
        bo_q    <= bo_q + seglen;
        count_q <= count_q + CW'(1);
        next_q  <= next_q + SW'(seglen);
        nseg_q  <= nseg_q + CW'(1);
      end
      if (cmd_i.tick) timer_q <= tsum[32] ? '1 : tsum[31:0];
      if (cmd_i.retx_upd) begin
        if (win_q != 16'd0) begin
          tmo_q <= tmo_q[31] ? '1 : {tmo_q[30:0], 1'b0};
          if (retries_q != 16'hFFFF) retries_q <= retries_q + 16'd1;
        end
        timer_q <= '0;
      end
      if (cmd_i.out_next) oidx_q <= oidx_q + CW'(1);
    end
  end

  // item latch, ack target, queue memory and result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
    if (cmd_i.unwrap) ack_abs_q <= abs_d;
    if (cmd_i.fill_begin) fstart_q <= tail_idx;
    if (cmd_i.fill_step) mem[tail_idx] <= {next_q, LEN_W'(plen), f_syn, f_fin};
    if (cmd_i.rd_head || cmd_i.rd_out) rdata_q <= mem[rd_idx];
    if (cmd_i.emit) begin
      res_q.kind             <= cmd_i.emit_kind;
      res_q.last             <= cmd_i.emit_last;
      res_q.flight_bytes     <= bo_q;
      res_q.retry_count      <= retries_q;
      res_q.written_accepted <= acc_q;
      if (cmd_i.emit_kind == KIND_NEW || cmd_i.emit_kind == KIND_RETX) begin
        res_q.wrapped_seqno <= isn_i + r_abs[31:0];
        res_q.syn_flag      <= r_syn;
        res_q.fin_flag      <= r_fin;
        res_q.payload_len   <= r_len[10:0];
      end else begin
        res_q.wrapped_seqno <= isn_i + next_q[31:0];
        res_q.syn_flag      <= 1'b0;
        res_q.fin_flag      <= 1'b0;
        res_q.payload_len   <= '0;
      end
    end
  end

  always_comb begin
    st_o.action    = item_q.action;
    st_o.ack_ok    = ack_abs_q <= {1'b0, next_q};
    st_o.count_nz  = count_q != '0;
    st_o.head_done = (count_q != '0) && (r_end <= ack_abs_q);
    st_o.fill_go   = f_go;
    st_o.nseg_nz   = nseg_q != '0;
    st_o.out_last  = (oidx_q + CW'(1)) == nseg_q;
    st_o.expire    = (count_q != '0) && (timer_q >= tmo_q);
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== hdl/tcp_sender_window_retransmit_top.sv =====
// tcp_sender_window_retransmit_top: tcp sender window and retransmit bookkeeping
// instantiates tsw_regs, tsw_ctrl and tsw_dp; depends on tsw_pkg
//
// usage: an item word on item_i is taken when start is high and busy is low.
// each item gives one or more result words on res_o, each marked by a
// one-cycle res_valid_o pulse; the last one of an item has last set.
// results cannot be held off, the receiver must take them as they come.
// write, empty segment and unused codes give their word after dispatch, an ignored
// ack and a tick without expiry after a check, a tick that expires after the head read.
// fill cuts one segment per cycle, then reads each segment word back from the
// queue memory (one read port, registered) and shows it. an ack first reads and
// retires each acknowledged head segment, then fills.
// busy stays high from accept until the last word of the item is shown.
// reset sets all sender state to its start values, the queue is empty and the registers
// return to isn 0, timeout 1000 ms, capacity 64000 bytes.
// registers sit on the apb port at 0x0, 0x4, 0x8; write them only while idle.
module tcp_sender_window_retransmit_top
  import tsw_pkg::*;
#(
  parameter int MAX_PAYLOAD  = 1452,
  parameter int FLIGHT_DEPTH = 64,
  parameter int SEQ_WIDTH    = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_item_t    item_i,
  output logic        res_valid_o,
  output out_item_t   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] isn;
  logic [15:0] init_tmo, capacity;
  cmd_t        cmd;
  stat_t       st;

  tsw_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .isn_o      (isn),
    .init_tmo_o (init_tmo),
    .capacity_o (capacity)
  );

  tsw_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .st_i   (st),
    .cmd_o  (cmd)
  );

  tsw_dp #(
    .MAX_PAYLOAD  (MAX_PAYLOAD),
    .FLIGHT_DEPTH (FLIGHT_DEPTH),
    .SEQ_WIDTH    (SEQ_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .isn_i       (isn),
    .init_tmo_i  (init_tmo),
    .capacity_i  (capacity),
    .cmd_i       (cmd),
    .st_o        (st),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // a word that is not the last of its item comes while the item is open
  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy)
    else $error("non-last result word outside a busy item");

  // an accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // nothing follows the last word of an item in the next cycle
  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |=> !res_valid_o)
    else $error("result word right after last");

endmodule

// ===== sim/tcp_sender_window_retransmit_top_test.sv =====
// tcp_sender_window_retransmit_top_test: self-checking bench for the tcp sender window block
// drives command words and apb register writes, predicts result words in-bench
// depends on tsw_pkg and tcp_sender_window_retransmit_top
`timescale 1ns / 100ps

module tcp_sender_window_retransmit_top_test;
  import tsw_pkg::*;

  localparam int MAX_PL = 1452;
  localparam int DEPTH  = 64;
  localparam logic [47:0] SEQ_MASK = 48'hFFFF_FFFF_FFFF;

  typedef struct {
    logic [47:0] seq;
    logic [15:0] len;
    logic        syn;
    logic        fin;
  } flight_seg_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    item_i = '0;
  logic        res_valid_o;
  out_item_t   res_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tcp_sender_window_retransmit_top u_top (
    .clk_i, .rst_ni, .start, .busy, .item_i, .res_valid_o, .res_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #6 clk_i = ~clk_i;

  // sender model state
  logic [31:0] isn_q;
  logic [15:0] tmo_init_q;
  logic [15:0] cap_q;
  logic [47:0] next_seq;
  logic [15:0] outstanding;
  logic [15:0] peer_win;
  logic        syn_done;
  logic        fin_done;
  logic [31:0] rto_timer;
  logic [31:0] rto_cur;
  logic [15:0] retries;
  flight_seg_t flight [DEPTH];
  int          fl_head;
  int          fl_count;
  logic [15:0] buffered;
  logic        closed;

  in_item_t    pending_words[$];
  out_item_t   expected_words[$];
  out_item_t   item_words[$];
  int          mismatches = 0;
  int          idle_pct = 0;
  logic        drv_enable = 1'b0;

  function automatic out_item_t seg_word(logic [1:0] kind, logic [47:0] seq,
                                         logic syn, logic fin, logic [15:0] plen);
    out_item_t w;
    w = '0;
    w.kind = kind;
    w.wrapped_seqno = isn_q + seq[31:0];
    w.syn_flag = syn;
    w.fin_flag = fin;
    w.payload_len = plen[10:0];
    return w;
  endfunction

  function automatic int seg_span(flight_seg_t s);
    return int'(s.len) + int'(s.syn) + int'(s.fin);
  endfunction

  task automatic cut_segments();
    int win;
    int room;
    int plen;
    flight_seg_t s;
    win = (peer_win == 0) ? 1 : int'(peer_win);
    while (win > int'(outstanding) && fl_count < DEPTH && item_words.size() < 64) begin
      s.syn = !syn_done;
      s.fin = 1'b0;
      room = win - int'(outstanding) - int'(s.syn);
      plen = room < MAX_PL ? room : MAX_PL;
      if (plen > int'(buffered)) plen = int'(buffered);
      if (!fin_done && closed && int'(buffered) == plen && plen + int'(outstanding) < win)
        s.fin = 1'b1;
      s.len = plen[15:0];
      if (!s.syn && !s.fin && plen == 0) break;
      buffered = buffered - plen[15:0];
      if (s.syn) syn_done = 1'b1;
      if (s.fin) fin_done = 1'b1;
      if (fl_count == 0) begin
        rto_cur = {16'd0, tmo_init_q};
        rto_timer = '0;
      end
      s.seq = next_seq;
      item_words.push_back(seg_word(KIND_NEW, next_seq, s.syn, s.fin, s.len));
      outstanding = 16'(int'(outstanding) + seg_span(s));
      flight[(fl_head + fl_count) % DEPTH] = s;
      fl_count++;
      next_seq = (next_seq + 48'(seg_span(s))) & SEQ_MASK;
      if (s.fin) break;
    end
  endtask

  // full-width result, may lie above the 48-bit sequence space
  function automatic logic [63:0] unwrap_ackno(logic [31:0] ackno);
    logic [63:0] cp;
    logic [63:0] c;
    cp = {16'd0, next_seq};
    c = {cp[63:32], ackno - isn_q};
    if (c > cp && c - cp > 64'h8000_0000 && c >= 64'h1_0000_0000)
      c = c - 64'h1_0000_0000;
    else if (c < cp && cp - c > 64'h8000_0000)
      c = c + 64'h1_0000_0000;
    return c;
  endfunction

  task automatic predict_item(in_item_t it);
    logic [15:0] accepted;
    logic [15:0] room;
    logic [63:0] ack_abs;
    logic [63:0] tsum;
    logic        rst_done;
    flight_seg_t s;
    out_item_t   w;
    accepted = '0;
    item_words.delete();
    case (it.action)
      ACT_WRITE: begin
        if (!closed) begin
          room = cap_q > buffered ? cap_q - buffered : 16'd0;
          accepted = it.write_len < room ? it.write_len : room;
          buffered = buffered + accepted;
          if (it.end_input) closed = 1'b1;
        end
      end
      ACT_FILL: cut_segments();
      ACT_ACK: begin
        ack_abs = unwrap_ackno(it.ack_number);
        if (ack_abs <= {16'd0, next_seq}) begin
          rst_done = 1'b0;
          while (fl_count > 0) begin
            s = flight[fl_head];
            if ({16'd0, s.seq} + 64'(seg_span(s)) > ack_abs) break;
            outstanding = 16'(int'(outstanding) - seg_span(s));
            fl_head = (fl_head + 1) % DEPTH;
            fl_count--;
            if (!rst_done) begin
              rto_cur = {16'd0, tmo_init_q};
              rto_timer = '0;
              retries = '0;
              rst_done = 1'b1;
            end
          end
          peer_win = it.advertised_window;
          cut_segments();
        end
      end
      ACT_TICK: begin
        tsum = {32'd0, rto_timer} + {48'd0, it.elapsed_ms};
        rto_timer = tsum > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : tsum[31:0];
        if (fl_count > 0 && rto_timer >= rto_cur) begin
          s = flight[fl_head];
          item_words.push_back(seg_word(KIND_RETX, s.seq, s.syn, s.fin, s.len));
          if (peer_win > 0) begin
            rto_cur = rto_cur > 32'h7FFF_FFFF ? 32'hFFFF_FFFF : rto_cur << 1;
            if (retries != 16'hFFFF) retries++;
          end
          rto_timer = '0;
        end
      end
      ACT_EMPTY: item_words.push_back(seg_word(KIND_EMPTY, next_seq, 1'b0, 1'b0, 16'd0));
      default: ;
    endcase
    if (item_words.size() == 0)
      item_words.push_back(seg_word(KIND_STATUS, next_seq, 1'b0, 1'b0, 16'd0));
    foreach (item_words[i]) begin
      w = item_words[i];
      w.last = (i == item_words.size() - 1);
      w.flight_bytes = outstanding;
      w.retry_count = retries;
      w.written_accepted = accepted;
      expected_words.push_back(w);
    end
  endtask

  // driver: one word per accept, random idle gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) predict_item(item_i);
      if ((!start || !busy) && drv_enable && pending_words.size() > 0 &&
          !(start && !busy && pending_words.size() == 0) &&
          $urandom_range(99) >= idle_pct) begin
        item_i <= pending_words.pop_front();
        start <= 1'b1;
      end else if (!start || !busy) begin
        start <= 1'b0;
      end
    end
  end

  // monitor: results cannot be stalled, check every strobe
  always @(posedge clk_i) begin
    out_item_t exp_w;
    if (rst_ni && res_valid_o) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", res_o);
      end else begin
        exp_w = expected_words.pop_front();
        if (res_o !== exp_w) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_w, res_o);
        end
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_ISN: isn_q = val;
      REG_TMO: tmo_init_q = val[15:0];
      REG_CAP: cap_q = val[15:0];
      default: ;
    endcase
  endtask

  function automatic in_item_t mk(logic [2:0] act, logic [15:0] wl, logic e,
                                  logic [31:0] ackno, logic [15:0] win, logic [15:0] ms);
    in_item_t it;
    it.action = act; it.write_len = wl; it.end_input = e;
    it.ack_number = ackno; it.advertised_window = win; it.elapsed_ms = ms;
    return it;
  endfunction

  // random item biased toward a working connection
  function automatic in_item_t rand_item();
    in_item_t it;
    int r;
    logic [31:0] sent_hi;
    it = in_item_t'($bits(in_item_t)'({$urandom, $urandom, $urandom}));
    r = $urandom_range(99);
    sent_hi = isn_q + next_seq[31:0];
    if (r < 25) begin
      it.action = ACT_WRITE;
      it.end_input = ($urandom_range(30) == 0);
      if ($urandom_range(3) != 0) it.write_len = 16'($urandom_range(6000));
    end else if (r < 45) begin
      it.action = ACT_FILL;
    end else if (r < 75) begin
      it.action = ACT_ACK;
      if ($urandom_range(5) != 0) it.ack_number = sent_hi - $urandom_range(outstanding);
      if ($urandom_range(4) != 0) it.advertised_window = 16'($urandom_range(9000));
    end else if (r < 90) begin
      it.action = ACT_TICK;
      if ($urandom_range(2) != 0) it.elapsed_ms = 16'($urandom_range(2500));
    end else if (r < 95) begin
      it.action = ACT_EMPTY;
    end else begin
      it.action = 3'($urandom_range(7, 5));
    end
    return it;
  endfunction

  task automatic drain();
    while (pending_words.size() > 0 || start || busy || expected_words.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic reset_model();
    next_seq = '0; outstanding = '0; peer_win = 16'd1;
    syn_done = 1'b0; fin_done = 1'b0; rto_timer = '0;
    rto_cur = {16'd0, tmo_init_q}; retries = '0;
    fl_head = 0; fl_count = 0; buffered = '0; closed = 1'b0;
  endtask

  initial begin
    isn_q = ISN_RST; tmo_init_q = TMO_RST; cap_q = CAP_RST;
    reset_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: handshake, big writes, zero window, expiry, wrap isn
    reg_write(REG_ISN, 32'hFFFF_FFF0);
    reg_write(REG_TMO, 32'd0);
    reg_write(REG_CAP, 32'h0000_FFFF);
    pending_words.push_back(mk(ACT_FILL, 0, 0, 0, 0, 0));
    pending_words.push_back(mk(ACT_TICK, 0, 0, 0, 0, 0));
    pending_words.push_back(mk(ACT_ACK, 0, 0, 32'hFFFF_FFF1, 16'hFFFF, 0));
    pending_words.push_back(mk(ACT_WRITE, 16'hFFFF, 0, 0, 0, 0));
    pending_words.push_back(mk(ACT_WRITE, 16'd10, 0, 0, 0, 0));
    pending_words.push_back(mk(ACT_FILL, 0, 0, 0, 0, 0));
    pending_words.push_back(mk(ACT_ACK, 0, 0, 32'h7000_0000, 16'd5, 0));
    pending_words.push_back(mk(ACT_TICK, 0, 0, 0, 0, 16'hFFFF));
    pending_words.push_back(mk(ACT_ACK, 0, 0, 32'h0000_1000, 16'd0, 0));
    pending_words.push_back(mk(ACT_TICK, 0, 0, 0, 0, 16'hFFFF));
    pending_words.push_back(mk(ACT_EMPTY, 0, 0, 0, 0, 0));
    pending_words.push_back(mk(3'd7, 16'hFFFF, 1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    pending_words.push_back(mk(ACT_WRITE, 16'd0, 1, 0, 0, 0));
    pending_words.push_back(mk(ACT_WRITE, 16'd50, 1, 0, 0, 0));
    pending_words.push_back(mk(ACT_ACK, 0, 0, 32'hFFFF_FFFF, 16'hFFFF, 0));
    pending_words.push_back(mk(ACT_FILL, 0, 0, 0, 0, 0));
    drv_enable = 1'b1;
    drain();
    // random phases with different settings and idling
    for (int ph = 0; ph < 4; ph++) begin
      drv_enable = 1'b0;
      case (ph)
        0: begin reg_write(REG_TMO, 32'h0000_FFFF); reg_write(REG_CAP, 32'd0);
                 idle_pct = 0; end
        1: begin reg_write(REG_TMO, 32'd300); reg_write(REG_CAP, 32'd20000);
                 idle_pct = 47; end
        2: begin reg_write(REG_ISN, $urandom); reg_write(REG_CAP, 32'd3000);
                 idle_pct = 19; end
        default: begin reg_write(REG_ISN, 32'd0); reg_write(REG_TMO, 32'd1);
                       reg_write(REG_CAP, 32'h0000_FFFF); idle_pct = 0; end
      endcase
      for (int n = 0; n < 50; n++) pending_words.push_back(rand_item());
      drv_enable = 1'b1;
      drain();
    end
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule
